@@ rtl/core/srtc_pkg.sv @@
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared types, widths, command codes and the BCD helper for the serial
// real-time-clock shift register.
// ----------------------------------------------------------------------------
package srtc_pkg;

	localparam int REG_W       = 40;
	localparam int STAMP_W     = 32;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 48;

	// Reciprocal of ten for values below 64: (v * 205) >> 11 equals v / 10.
	localparam logic [13:0] BCD_RECIP = 14'd205;
	localparam int          BCD_SHIFT = 11;

	localparam logic [STAMP_W-1:0] STAMP_RESET = 32'd1;

	typedef enum logic [2:0] {
		CODE_NOP   = 3'd0,
		CODE_SHIFT = 3'd1,
		CODE_WRITE = 3'd2,
		CODE_READ  = 3'd3
	} code_t;

	typedef logic [REG_W-1:0] reg_word_t;

	typedef struct packed {
		logic               command;
		logic [2:0]         mode_value;
		logic               data_in;
		logic [STAMP_W-1:0] host_stamp;
		logic [5:0]         host_second;
		logic [5:0]         host_minute;
		logic [4:0]         host_hour;
		logic [4:0]         host_day;
		logic [2:0]         host_weekday;
		logic [3:0]         host_month;
	} item_t;

	typedef struct packed {
		logic      serial_out;
		reg_word_t shift_contents;
	} result_t;

	// Tens digit in the high nibble, units in the low nibble.
	function automatic logic [7:0] bcd_byte(input logic [5:0] v);
		logic [13:0] prod;
		logic [2:0]  tens;
		logic [5:0]  units;
		prod  = 14'(v) * BCD_RECIP;
		tens  = prod[BCD_SHIFT+2:BCD_SHIFT];
		units = v - 6'(6'(tens) * 6'd10);
		return {1'b0, tens, units[3:0]};
	endfunction

endpackage

@@ rtl/core/srtc_time_enc.sv @@
// ----------------------------------------------------------------------------
// srtc_time_enc
// Builds the 40-bit clock word from the host wall clock fields.
// ----------------------------------------------------------------------------
module srtc_time_enc
	import srtc_pkg::*;
(
	input  item_t     item,
	output reg_word_t load_word
);

	logic [3:0] month_nib;

	// Month is held as month plus one, wrapping within the nibble.
	assign month_nib = item.host_month + 4'd1;

	assign load_word = {
		month_nib,
		1'b0, item.host_weekday,
		bcd_byte({1'b0, item.host_day}),
		bcd_byte({1'b0, item.host_hour}),
		bcd_byte(item.host_minute),
		bcd_byte(item.host_second)
	};

endmodule

@@ rtl/core/srtc_state.sv @@
// ----------------------------------------------------------------------------
// srtc_state
// Holds the shift register, saved copy, mode, serial bit and last stamp, and
// applies one item to them per step.
// ----------------------------------------------------------------------------
module srtc_state
	import srtc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  item_t   item,
	output result_t res_next
);

	reg_word_t          shift_reg_q, shift_reg_d;
	reg_word_t          saved_reg_q, saved_reg_d;
	logic               shift_mode_q, shift_mode_d;
	logic               serial_bit_q, serial_bit_d;
	logic [STAMP_W-1:0] last_stamp_q, last_stamp_d;
	reg_word_t          load_word;

	srtc_time_enc u_time_enc (
		.item      (item),
		.load_word (load_word)
	);

	always_comb begin
		shift_reg_d  = shift_reg_q;
		saved_reg_d  = saved_reg_q;
		shift_mode_d = shift_mode_q;
		serial_bit_d = serial_bit_q;
		last_stamp_d = last_stamp_q;
		if (!item.command) begin
			shift_mode_d = (item.mode_value == CODE_SHIFT);
			unique case (code_t'(item.mode_value))
				CODE_SHIFT: begin
					serial_bit_d = shift_reg_q[0];
				end
				CODE_WRITE: begin
					saved_reg_d = shift_reg_q;
				end
				CODE_READ: begin
					shift_reg_d = saved_reg_q;
					if (item.host_stamp != last_stamp_q) begin
						last_stamp_d = item.host_stamp;
						shift_reg_d  = load_word;
						saved_reg_d  = load_word;
					end
				end
				default: begin
				end
			endcase
		end else if (shift_mode_q) begin
			shift_reg_d  = {item.data_in, shift_reg_q[REG_W-1:1]};
			serial_bit_d = shift_reg_q[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_reg_q  <= '0;
			saved_reg_q  <= '0;
			shift_mode_q <= 1'b0;
			serial_bit_q <= 1'b0;
			last_stamp_q <= STAMP_RESET;
		end else if (step) begin
			shift_reg_q  <= shift_reg_d;
			saved_reg_q  <= saved_reg_d;
			shift_mode_q <= shift_mode_d;
			serial_bit_q <= serial_bit_d;
			last_stamp_q <= last_stamp_d;
		end
	end

	assign res_next.serial_out     = serial_bit_d;
	assign res_next.shift_contents = shift_reg_d;

	// A pulse outside shift mode must leave the register untouched.
	a_pulse_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.command && !shift_mode_q) |=> $stable(shift_reg_q))
		else $error("pulse outside shift mode changed the register");

	// After a shifting pulse the serial bit follows the new bit 0.
	a_serial_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.command && shift_mode_q) |=> (serial_bit_q == shift_reg_q[0]))
		else $error("serial bit does not follow bit 0 after a shift");

	// A write strobe copies the register into the saved copy.
	a_write_saves: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.command && (item.mode_value == CODE_WRITE))
		|=> (saved_reg_q == $past(shift_reg_q)))
		else $error("write strobe did not save the register");

	// A read with a new stamp records that stamp.
	a_stamp_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.command && (item.mode_value == CODE_READ)
			&& (item.host_stamp != last_stamp_q))
		|=> (last_stamp_q == $past(item.host_stamp)))
		else $error("new stamp not recorded on read");

endmodule

@@ rtl/core/serial_rtc_shift_register.sv @@
// ----------------------------------------------------------------------------
// serial_rtc_shift_register
// Serial real-time-clock chip interface driven by a stream of strobes and
// clock pulses, reporting the serial bit and register after each one.
// ----------------------------------------------------------------------------
// Each input transaction is either a command strobe (s_tuser low) that sets
// the mode and may save, restore or reload the 40-bit register from the host
// wall clock, or a serial clock pulse (s_tuser high) that shifts the register
// right by one with data_in entering at bit 39, but only while shift mode is
// set. Every input transaction yields exactly one output transaction carrying
// the serial output bit and the register contents after that item. The block
// takes one transaction per clock while the master side is not stalling: an
// item sits in the input register while the state registers and the result
// register are updated from it, so the result reaches the master side from
// the result register after passing through the input register. Throughput
// is limited only by the master side: while the result register is held by
// a low m_tready, the input register stalls and, once it also holds an item,
// s_tready falls. The clock word loaded on a read holds BCD seconds,
// minutes, hour and day in bytes 0 to 3, and weekday in the low nibble and
// month plus one in the high nibble of byte 4.
module serial_rtc_shift_register
	import srtc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// s_tdata, from bit 0: mode_value[3], data_in[1], host_stamp[32],
	// host_second[6], host_minute[6], host_hour[5], host_day[5],
	// host_weekday[3], host_month[4], zero padding[7]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// s_tuser: command (0 strobe, 1 serial clock pulse)
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// m_tdata, from bit 0: serial_out[1], shift_contents[40], zero padding[7]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic    s1_valid;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t res_next;
	logic    advance;
	logic    step;
	item_t   item_in;

	// Unpack the incoming transaction into the item fields.
	assign item_in.command      = s_tuser;
	assign item_in.mode_value   = s_tdata[2:0];
	assign item_in.data_in      = s_tdata[3];
	assign item_in.host_stamp   = s_tdata[35:4];
	assign item_in.host_second  = s_tdata[41:36];
	assign item_in.host_minute  = s_tdata[47:42];
	assign item_in.host_hour    = s_tdata[52:48];
	assign item_in.host_day     = s_tdata[57:53];
	assign item_in.host_weekday = s_tdata[60:58];
	assign item_in.host_month   = s_tdata[64:61];

	// The result register can take a new value when it is empty or being
	// drained this cycle; the input register moves along with it.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !s1_valid || advance;
	assign step     = s1_valid && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
	end

	srtc_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.res_next (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, result_q.shift_contents, result_q.serial_out};

	// An item held in the input register is not lost while the output stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !advance) |=> (s1_valid && $stable(item_s1)))
		else $error("stalled item left the input register");

	// Every item that steps produces a result in the next cycle.
	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid_q)
		else $error("stepped item produced no result");

	// The input side is never refused while the input register is empty.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid |-> s_tready)
		else $error("input refused with an empty input register");

endmodule
